// ----- rtl/hdmp_pkg.sv -----
// Package for the hierarchical depth max pyramid.
// Holds frame size constants, the level-1 item type and the depth maximum helper.
// No dependencies.
package hdmp_pkg;

    // Frame geometry and pyramid height.
    localparam int BASE_DIM = 64;
    localparam int LEVELS   = 3;

    // Field widths.
    localparam int DEPTH_W     = 25;
    localparam int LVL_W       = 2;
    localparam int OUT_COORD_W = 5;
    localparam int COORD_W     = $clog2(BASE_DIM);
    localparam int L1_W        = COORD_W - 1;

    // Stream widths, packed to whole bytes.
    localparam int S_TDATA_W = ((DEPTH_W + 7) / 8) * 8;
    localparam int M_FIELD_W = LVL_W + 2 * OUT_COORD_W + DEPTH_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Level codes as they appear on the output.
    localparam logic [LVL_W-1:0] LVL_ONE = 2'd0;

    typedef logic [DEPTH_W-1:0] depth_t;

    // A completed level-1 block on its way to the back part.
    typedef struct packed {
        logic [L1_W-1:0] col;
        logic [L1_W-1:0] row;
        depth_t          depth;
    } l1_item_t;

    function automatic depth_t depth_max(input depth_t a, input depth_t b);
        return (a > b) ? a : b;
    endfunction

    // Low bits of a level coordinate, zero-extended when the level is narrow.
    function automatic logic [OUT_COORD_W-1:0] out_coord(input logic [L1_W-1:0] x);
        logic [L1_W+OUT_COORD_W-1:0] ext;
        ext = {{OUT_COORD_W{1'b0}}, x};
        return ext[OUT_COORD_W-1:0];
    endfunction

endpackage

// ----- rtl/hdmp_front.sv -----
// Front part of the depth pyramid: raster position, level-0 pairing and level-1 line store.
// Pushes each completed level-1 block into the queue. Depends on hdmp_pkg.
module hdmp_front import hdmp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 q_full,
    output logic                 push_valid,
    output l1_item_t             push_item
);

    logic               accept;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] cur_col, cur_row;
    logic               last_col, last_row;
    logic [L1_W-1:0]    idx;
    depth_t             sample;
    depth_t             hold_reg;
    depth_t             pair_max, blk_max;
    depth_t             line_reg [2**L1_W];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign sample   = s_tdata[DEPTH_W-1:0];

    // Position of this sample; a frame start moves it to the origin first.
    assign cur_col  = s_tuser ? '0 : col_reg;
    assign cur_row  = s_tuser ? '0 : row_reg;
    assign last_col = (cur_col == COORD_W'(BASE_DIM - 1));
    assign last_row = (cur_row == COORD_W'(BASE_DIM - 1));

    always_comb begin
        col_next = last_col ? '0 : cur_col + 1'b1;
        row_next = cur_row;
        if (last_col) begin
            row_next = last_row ? '0 : cur_row + 1'b1;
        end
    end

    // Level-1 block maximum from the held left sample and the stored top pair.
    assign idx      = cur_col[COORD_W-1:1];
    assign pair_max = depth_max(hold_reg, sample);
    assign blk_max  = depth_max(line_reg[idx], pair_max);

    assign push_valid      = accept && cur_col[0] && cur_row[0];
    assign push_item.col   = idx;
    assign push_item.row   = cur_row[COORD_W-1:1];
    assign push_item.depth = blk_max;

    // Position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Pair hold and line store updates.
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!cur_col[0]) begin
                hold_reg <= sample;
            end else if (!cur_row[0]) begin
                line_reg[idx] <= pair_max;
            end
        end
    end

endmodule

// ----- rtl/hdmp_queue.sv -----
// Short queue of completed level-1 blocks between the front and back parts.
// Depends on hdmp_pkg.
module hdmp_queue import hdmp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    input  l1_item_t push_item,
    input  logic     pop,
    output logic     head_valid,
    output l1_item_t head_item,
    output logic     full
);

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    l1_item_t          slot_reg [QUEUE_DEPTH];
    logic              do_pop;

    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_pop     = pop && head_valid;

    // Pointer and fill count bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_valid && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/hdmp_back.sv -----
// Back part of the depth pyramid: emits level-1 blocks and builds levels 2 and 3.
// Owns the upper pair holds, line stores and the output register. Depends on hdmp_pkg.
module hdmp_back import hdmp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  l1_item_t             head_item,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    // Value being worked on and its place in the pyramid.
    logic              cur_valid_reg, cur_valid_next;
    logic [LVL_W-1:0]  cur_lvl_reg, cur_lvl_next;
    logic [L1_W-1:0]   cur_col_reg, cur_col_next;
    logic [L1_W-1:0]   cur_row_reg, cur_row_next;
    depth_t            cur_val_reg, cur_val_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [LVL_W-1:0]  out_lvl_reg;
    logic [L1_W-1:0]   out_col_reg, out_row_reg;
    depth_t            out_val_reg;
    logic              out_last_reg;

    // Level 2 and level 3 state.
    depth_t            hold2_reg, hold3_reg;
    depth_t            line2_reg [2**(L1_W-1)];
    depth_t            line3_reg [2**(L1_W-2)];

    logic              out_free, emit, has_next, completes, last;
    logic [L1_W-2:0]   idx2;
    logic [L1_W-3:0]   idx3;
    depth_t            hold_sel, line_sel, pair_max, blk_max;

    assign out_free  = !out_valid_reg || m_tready;
    assign emit      = out_free && cur_valid_reg;
    assign has_next  = (cur_lvl_reg < LVL_W'(LEVELS - 1));
    assign completes = has_next && cur_col_reg[0] && cur_row_reg[0];
    assign last      = !completes;

    // Next-level step for the value being emitted.
    assign idx2     = cur_col_reg[L1_W-1:1];
    assign idx3     = cur_col_reg[L1_W-2:1];
    assign hold_sel = (cur_lvl_reg == LVL_ONE) ? hold2_reg : hold3_reg;
    assign line_sel = (cur_lvl_reg == LVL_ONE) ? line2_reg[idx2] : line3_reg[idx3];
    assign pair_max = depth_max(hold_sel, cur_val_reg);
    assign blk_max  = depth_max(line_sel, pair_max);

    // Take a new level-1 block when idle or when the current run is done.
    assign pop = head_valid && (!cur_valid_reg || (emit && last));

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_lvl_next   = cur_lvl_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        cur_val_next   = cur_val_reg;
        if (emit && completes) begin
            cur_lvl_next = cur_lvl_reg + 1'b1;
            cur_col_next = cur_col_reg >> 1;
            cur_row_next = cur_row_reg >> 1;
            cur_val_next = blk_max;
        end else if (pop) begin
            cur_valid_next = 1'b1;
            cur_lvl_next   = LVL_ONE;
            cur_col_next   = head_item.col;
            cur_row_next   = head_item.row;
            cur_val_next   = head_item.depth;
        end else if (emit) begin
            cur_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = cur_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the working value and the output register.
    always_ff @(posedge aclk) begin
        cur_lvl_reg <= cur_lvl_next;
        cur_col_reg <= cur_col_next;
        cur_row_reg <= cur_row_next;
        cur_val_reg <= cur_val_next;
        if (emit) begin
            out_lvl_reg  <= cur_lvl_reg;
            out_col_reg  <= cur_col_reg;
            out_row_reg  <= cur_row_reg;
            out_val_reg  <= cur_val_reg;
            out_last_reg <= last;
        end
    end

    // Left values and top pairs of pending upper-level blocks.
    always_ff @(posedge aclk) begin
        if (emit && has_next) begin
            if (!cur_col_reg[0]) begin
                if (cur_lvl_reg == LVL_ONE) begin
                    hold2_reg <= cur_val_reg;
                end else begin
                    hold3_reg <= cur_val_reg;
                end
            end else if (!cur_row_reg[0]) begin
                if (cur_lvl_reg == LVL_ONE) begin
                    line2_reg[idx2] <= pair_max;
                end else begin
                    line3_reg[idx3] <= pair_max;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELD_W){1'b0}}, out_val_reg,
                       out_coord(out_row_reg), out_coord(out_col_reg), out_lvl_reg};

endmodule

// ----- rtl/hierarchical_depth_max_pyramid.sv -----
// Top level of the hierarchical depth max pyramid.
// Instantiates hdmp_front, hdmp_queue and hdmp_back. Depends on hdmp_pkg.
//
// Usage:
// The slave stream carries level-0 depth samples of a square frame in raster
// order, one sample per transfer. tuser set on a transfer moves the position to
// the frame origin before that sample; otherwise the position wraps at frame end.
// The master stream carries one transfer per completed 2x2 block at levels 1 to 3,
// in completion order: a level-1 value, then any level-2 and level-3 values that it
// completes. tlast marks the final transfer caused by one input sample.
// Each level-1 result passes the queue, the working register and the output register.
// The input side takes one sample per cycle while the queue is not full; the output
// side gives at most one result per cycle, set by the single output register, and a
// burst of up to three results is absorbed by the 4-entry queue of level-1 blocks
// between the front and back parts. Reset returns the position to the origin and
// empties the queue and output register; the depth stores need no clearing. When the
// receiver stalls, the queue fills and tready drops; no transfer is lost.
module hierarchical_depth_max_pyramid import hdmp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [24:0] depth_sample, rest zero
    input  logic                 s_tuser,   // [0] frame_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [1:0] pyramid_level, [6:2] out_col,
                                            // [11:7] out_row, [36:12] max_depth
    output logic                 m_tlast    // last_of_run
);

    logic     q_full;
    logic     push_valid;
    l1_item_t push_item;
    logic     pop;
    logic     head_valid;
    l1_item_t head_item;

    hdmp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    hdmp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .full       (q_full)
    );

    hdmp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for hierarchical_depth_max_pyramid: 2x2 max pyramid over depth frames.
// A class predicts each sample's results; the sender task and the receiver both insert gaps.
// Depends on hdmp_pkg and the RTL of hierarchical_depth_max_pyramid.
module tb_top;
    import hdmp_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int QUIET_FROM   = 290;
    localparam int QUIET_TO     = 390;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_LEN     = 100;
    localparam int TAIL_CYCLES  = 16;
    localparam int RANDOM_ITEMS = 214;
    localparam int RESYNC_FROM  = 200;

    localparam depth_t DEPTH_ONE = depth_t'(1 << 24);
    localparam depth_t DEPTH_ALL = {DEPTH_W{1'b1}};

    // One expected transfer on the result stream.
    typedef struct packed {
        logic [LVL_W-1:0]       level;
        logic [OUT_COORD_W-1:0] col;
        logic [OUT_COORD_W-1:0] row;
        depth_t                 depth;
        logic                   last;
    } pyramid_result_t;

    // Pyramid predictor plus the ordered store of results still owed by the block.
    class depth_pyramid_board;
        int unsigned     col_pos;
        int unsigned     row_pos;
        depth_t          pair_left[3];
        depth_t          line_top[3][BASE_DIM/2];
        pyramid_result_t owed[$];
        int              mismatches;

        function new();
            col_pos    = 0;
            row_pos    = 0;
            mismatches = 0;
            for (int lv = 0; lv < 3; lv++) begin
                pair_left[lv] = '0;
                for (int i = 0; i < BASE_DIM/2; i++) line_top[lv][i] = '0;
            end
        endfunction

        function depth_t larger(depth_t a, depth_t b);
            return (a > b) ? a : b;
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
        endfunction

        // Walks the sample up the pyramid and queues every block it completes.
        function void note_sample(depth_t sample, bit frame_start);
            int unsigned     c;
            int unsigned     r;
            int unsigned     idx;
            int              lv;
            int              n;
            bit              stop;
            depth_t          v;
            depth_t          m;
            pyramid_result_t burst[3];

            v    = sample;
            n    = 0;
            stop = 0;
            if (frame_start) begin
                col_pos = 0;
                row_pos = 0;
            end
            c = col_pos;
            r = row_pos;

            // Advance the raster position, wrapping at the frame end.
            col_pos++;
            if (col_pos >= BASE_DIM) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= BASE_DIM) row_pos = 0;
            end

            for (lv = 0; lv < LEVELS && lv < 3 && !stop; lv++) begin
                idx = c >> 1;
                if ((c & 1) == 0) begin
                    pair_left[lv] = v;
                    stop = 1;
                end else begin
                    m = larger(pair_left[lv], v);
                    if (idx >= (BASE_DIM >> (lv + 1))) begin
                        stop = 1;
                    end else if ((r & 1) == 0) begin
                        line_top[lv][idx] = m;
                        stop = 1;
                    end else begin
                        m = larger(line_top[lv][idx], m);
                        burst[n].level = lv[LVL_W-1:0];
                        burst[n].col   = idx[OUT_COORD_W-1:0];
                        burst[n].row   = OUT_COORD_W'(r >> 1);
                        burst[n].depth = m;
                        burst[n].last  = 1'b0;
                        n++;
                        v = m;
                        c = idx;
                        r = r >> 1;
                    end
                end
            end

            for (int i = 0; i < n; i++) begin
                burst[i].last = (i == n - 1);
                owed.push_back(burst[i]);
            end
        endfunction

        // Compares one result transfer with the oldest owed result.
        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tlast);
            pyramid_result_t want;
            pyramid_result_t got;

            got.level = tdata[1:0];
            got.col   = tdata[6:2];
            got.row   = tdata[11:7];
            got.depth = tdata[36:12];
            got.last  = tlast;
            if (owed.size() == 0) begin
                flag($sformatf("unexpected result lvl=%0d col=%0d row=%0d depth=%h last=%b",
                               got.level, got.col, got.row, got.depth, got.last));
            end else begin
                want = owed.pop_front();
                if (got !== want) begin
                    flag($sformatf({"expected lvl=%0d col=%0d row=%0d depth=%h last=%b, ",
                                    "got lvl=%0d col=%0d row=%0d depth=%h last=%b"},
                                   want.level, want.col, want.row, want.depth, want.last,
                                   got.level, got.col, got.row, got.depth, got.last));
                end
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int                 cycle_count = 0;
    logic               hold_off    = 1'b0;
    depth_pyramid_board board       = new();

    hierarchical_depth_max_pyramid i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Free-running clock.
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Cycle counter for idle windows, the hold-off and the run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Random idling with a probability of about one in three, except inside the quiet window.
    function automatic bit idle_roll();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
        return $urandom_range(99) < 33;
    endfunction

    // Offers one sample, with random gaps before it, and records it once transferred.
    task automatic send_sample(input depth_t depth, input bit frame_start);
        while (idle_roll()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(depth);
        s_tuser  <= frame_start;
        do @(posedge aclk); while (!s_tready);
        board.note_sample(depth, frame_start);
    endtask

    // Receiver: checks every result transfer and stalls at random.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tlast);
            m_tready <= !(hold_off || idle_roll());
        end
    end

    // One long receiver stall while the sender keeps offering, so the queue fills.
    initial begin
        while (cycle_count < HOLD_AT) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Run limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("[hierarchical_depth_max_pyramid] ERROR");
        $finish;
    end

    // Main sequence: reset, directed samples, then a random partial frame.
    initial begin
        depth_t directed[16];
        bit     directed_sof[16];
        depth_t depth;
        bit     frame_start;

        directed = '{25'd0, DEPTH_ONE, DEPTH_ALL, 25'd1, 25'h0AAAAAA, 25'h1555555,
                     DEPTH_ONE - 25'd1, 25'd0, DEPTH_ALL, DEPTH_ONE, 25'd2, 25'h1000001,
                     25'h0800000, DEPTH_ALL, 25'd0, DEPTH_ONE};
        directed_sof = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes of the depth field and a mid-frame resync; no block completes here.
        for (int i = 0; i < 16; i++) send_sample(directed[i], directed_sof[i]);

        // The first rows of a frame from the origin reach level 2; near the end
        // occasional resyncs abandon the partial frame.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(15))
                0, 1:    depth = '0;
                2, 3:    depth = DEPTH_ONE;
                4:       depth = DEPTH_ALL;
                5:       depth = depth_t'($urandom);
                default: depth = depth_t'($urandom_range(1 << 24));
            endcase
            frame_start = (n == 0) || (n > RESYNC_FROM && $urandom_range(9) == 0);
            send_sample(depth, frame_start);
        end
        s_tvalid <= 1'b0;

        // Drain the owed results, then watch for strays.
        while (board.owed.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (board.mismatches == 0 && board.owed.size() == 0) begin
            $display("[hierarchical_depth_max_pyramid] OK");
        end else begin
            $display("[hierarchical_depth_max_pyramid] ERROR");
        end
        $finish;
    end
endmodule
